/* design/drfd_pkg.sv */
package drfd_pkg;

  // Fixed field widths of the streams.
  localparam int Q16_W      = 32;
  localparam int CLASS_W    = 7;
  localparam int POINT_W    = 5;
  localparam int BOX_IDX_W  = 16;
  localparam int ELEM_IDX_W = 8;
  localparam int THR_W      = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 2;

  // Stream bus widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = CLASS_W + Q16_W + BOX_IDX_W + POINT_W + 4 * Q16_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Parameter defaults.
  localparam int MAX_ROW_LEN_DEF    = 128;
  localparam int ROW_INDEX_BITS_DEF = 16;

  // Row layout.
  localparam int BOX_READS    = 5;   // x, y, w, h, objectness
  localparam int CLS_BASE     = 5;
  localparam int CLS_BASE_V8  = 4;
  localparam int POSE_BASE    = 6;
  localparam int POSE_STRIDE  = 3;
  localparam int POSE_POINTS  = 17;
  localparam int FACE_BASE    = 5;
  localparam int FACE_STRIDE  = 2;
  localparam int FACE_POINTS  = 5;

  localparam logic signed [Q16_W-1:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [Q16_W-1:0] HALF_Q16 = 32'sd32768;

  // Head modes.
  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_V8     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POSE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FACE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAD_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLASS_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OBJ_THR     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLS_THR     = 2'd3;

  localparam logic [MODE_W-1:0]  HEAD_MODE_RST   = MODE_DETECT;
  localparam logic [CLASS_W-1:0] CLASS_COUNT_RST = 7'd80;
  localparam logic [THR_W-1:0]   OBJ_THR_RST     = 17'd16384;
  localparam logic [THR_W-1:0]   CLS_THR_RST     = 17'd16384;

  typedef logic signed [Q16_W-1:0] q16_t;
  typedef logic [CLASS_W-1:0]      cls_t;
  typedef logic [POINT_W-1:0]      pnt_t;
  typedef logic [ELEM_IDX_W-1:0]   idx_t;
  typedef logic [BOX_IDX_W-1:0]    box_idx_t;

  typedef enum logic [3:0] {
    S_IN,
    S_LOAD,
    S_LOAD_WAIT,
    S_OBJ_CHK,
    S_SCAN,
    S_SCAN_WAIT,
    S_BOX,
    S_KP_RD,
    S_KP_WAIT,
    S_KP_EMIT,
    S_FINISH
  } state_t;

  // Where the element fetched by a read goes; the tag is registered alongside the read data.
  typedef enum logic [3:0] {
    LD_NONE,
    LD_X,
    LD_Y,
    LD_W,
    LD_H,
    LD_OBJ,
    LD_SCAN,
    LD_KA,
    LD_KB,
    LD_KC
  } ld_dest_t;

  typedef struct packed {
    logic     in_take;
    logic     rd_en;
    idx_t     rd_idx;
    ld_dest_t rd_dest;
    cls_t     rd_cls;
    logic     init_best;
    logic     emit_box;
    logic     emit_kp;
    pnt_t     point;
    logic     emit_last;
    logic     end_row;
  } ctrl_cmd_t;

  typedef struct packed {
    logic obj_pass;
    logic found;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic     kind;
    cls_t     class_label;
    q16_t     score;
    box_idx_t box_index;
    pnt_t     point_number;
    q16_t     coord_a;
    q16_t     coord_b;
    q16_t     coord_c;
    q16_t     coord_d;
    logic     last_of_run;
  } result_t;

endpackage

/* design/drfd_ctrl.sv */
module drfd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tlast,
  output logic                            s_tready,
  input  logic [drfd_pkg::MODE_W-1:0]     head_mode,
  input  drfd_pkg::cls_t                  class_count,
  input  drfd_pkg::dp_status_t            status,
  output drfd_pkg::ctrl_cmd_t             cmd
);

  drfd_pkg::state_t state, state_next;
  drfd_pkg::cls_t   cnt;
  drfd_pkg::pnt_t   kp;
  logic [1:0]       sub;

  logic           is_pose;
  logic           kp_mode;
  logic           last_sub;
  logic           last_kp;
  logic           last_cls;
  drfd_pkg::idx_t cls_base;
  drfd_pkg::idx_t kp_base;

  always_comb begin
    is_pose  = (head_mode == drfd_pkg::MODE_POSE);
    kp_mode  = is_pose || (head_mode == drfd_pkg::MODE_FACE);
    last_sub = is_pose ? (sub == 2'(drfd_pkg::POSE_STRIDE - 1))
                       : (sub == 2'(drfd_pkg::FACE_STRIDE - 1));
    last_kp  = is_pose ? (kp == drfd_pkg::pnt_t'(drfd_pkg::POSE_POINTS - 1))
                       : (kp == drfd_pkg::pnt_t'(drfd_pkg::FACE_POINTS - 1));
    last_cls = (drfd_pkg::cls_t'(cnt + 1'b1) == class_count);
    cls_base = (head_mode == drfd_pkg::MODE_V8) ? drfd_pkg::idx_t'(drfd_pkg::CLS_BASE_V8)
                                                : drfd_pkg::idx_t'(drfd_pkg::CLS_BASE);
    if (is_pose) begin
      kp_base = drfd_pkg::idx_t'(drfd_pkg::POSE_BASE)
              + drfd_pkg::idx_t'(kp) * drfd_pkg::idx_t'(drfd_pkg::POSE_STRIDE);
    end else begin
      kp_base = drfd_pkg::idx_t'(drfd_pkg::FACE_BASE)
              + drfd_pkg::idx_t'(kp) * drfd_pkg::idx_t'(drfd_pkg::FACE_STRIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drfd_pkg::S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      kp  <= '0;
      sub <= '0;
    end else begin
      if (state == drfd_pkg::S_LOAD || state == drfd_pkg::S_SCAN) begin
        cnt <= (state_next == state) ? drfd_pkg::cls_t'(cnt + 1'b1) : '0;
      end
      if (state == drfd_pkg::S_KP_RD) begin
        sub <= last_sub ? '0 : 2'(sub + 1'b1);
      end
      if (state == drfd_pkg::S_BOX) begin
        kp <= '0;
      end else if (state == drfd_pkg::S_KP_EMIT && status.out_free) begin
        kp <= drfd_pkg::pnt_t'(kp + 1'b1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      drfd_pkg::S_IN: begin
        if (s_tvalid && s_tlast) state_next = drfd_pkg::S_LOAD;
      end
      drfd_pkg::S_LOAD: begin
        if (cnt == drfd_pkg::cls_t'(drfd_pkg::BOX_READS - 1)) state_next = drfd_pkg::S_LOAD_WAIT;
      end
      drfd_pkg::S_LOAD_WAIT: begin
        if (!status.pipe_busy) state_next = drfd_pkg::S_OBJ_CHK;
      end
      drfd_pkg::S_OBJ_CHK: begin
        if (status.obj_pass && class_count != '0) state_next = drfd_pkg::S_SCAN;
        else state_next = drfd_pkg::S_FINISH;
      end
      drfd_pkg::S_SCAN: begin
        if (last_cls) state_next = drfd_pkg::S_SCAN_WAIT;
      end
      drfd_pkg::S_SCAN_WAIT: begin
        if (!status.pipe_busy) begin
          state_next = status.found ? drfd_pkg::S_BOX : drfd_pkg::S_FINISH;
        end
      end
      drfd_pkg::S_BOX: begin
        if (status.out_free) state_next = kp_mode ? drfd_pkg::S_KP_RD : drfd_pkg::S_FINISH;
      end
      drfd_pkg::S_KP_RD: begin
        if (last_sub) state_next = drfd_pkg::S_KP_WAIT;
      end
      drfd_pkg::S_KP_WAIT: begin
        if (!status.pipe_busy) state_next = drfd_pkg::S_KP_EMIT;
      end
      drfd_pkg::S_KP_EMIT: begin
        if (status.out_free) state_next = last_kp ? drfd_pkg::S_FINISH : drfd_pkg::S_KP_RD;
      end
      drfd_pkg::S_FINISH: begin
        state_next = drfd_pkg::S_IN;
      end
      default: state_next = drfd_pkg::S_IN;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.rd_dest = drfd_pkg::LD_NONE;
    unique case (state)
      drfd_pkg::S_IN: begin
        s_tready    = 1'b1;
        cmd.in_take = s_tvalid;
      end
      drfd_pkg::S_LOAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = drfd_pkg::idx_t'(cnt);
        case (cnt)
          7'd0:    cmd.rd_dest = drfd_pkg::LD_X;
          7'd1:    cmd.rd_dest = drfd_pkg::LD_Y;
          7'd2:    cmd.rd_dest = drfd_pkg::LD_W;
          7'd3:    cmd.rd_dest = drfd_pkg::LD_H;
          default: cmd.rd_dest = drfd_pkg::LD_OBJ;
        endcase
      end
      drfd_pkg::S_OBJ_CHK: begin
        cmd.init_best = 1'b1;
      end
      drfd_pkg::S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_idx  = drfd_pkg::idx_t'(cls_base + drfd_pkg::idx_t'(cnt));
        cmd.rd_dest = drfd_pkg::LD_SCAN;
        cmd.rd_cls  = cnt;
      end
      drfd_pkg::S_BOX: begin
        cmd.emit_box  = status.out_free;
        cmd.emit_last = !kp_mode;
      end
      drfd_pkg::S_KP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = drfd_pkg::idx_t'(kp_base + drfd_pkg::idx_t'(sub));
        case (sub)
          2'd0:    cmd.rd_dest = drfd_pkg::LD_KA;
          2'd1:    cmd.rd_dest = drfd_pkg::LD_KB;
          default: cmd.rd_dest = drfd_pkg::LD_KC;
        endcase
      end
      drfd_pkg::S_KP_EMIT: begin
        cmd.emit_kp   = status.out_free;
        cmd.point     = kp;
        cmd.emit_last = last_kp;
      end
      drfd_pkg::S_FINISH: begin
        cmd.end_row = 1'b1;
      end
      default: begin
        cmd.end_row = 1'b0;
      end
    endcase
  end

endmodule

/* design/drfd_datapath.sv */
module drfd_datapath #(
  parameter int MAX_ROW_LEN    = drfd_pkg::MAX_ROW_LEN_DEF,
  parameter int ROW_INDEX_BITS = drfd_pkg::ROW_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  drfd_pkg::ctrl_cmd_t           cmd,
  output drfd_pkg::dp_status_t          status,
  input  drfd_pkg::q16_t                value,
  input  logic                          first,
  input  logic [drfd_pkg::MODE_W-1:0]   head_mode,
  input  logic [drfd_pkg::THR_W-1:0]    obj_thr,
  input  logic [drfd_pkg::THR_W-1:0]    cls_thr,
  input  logic                          out_ready,
  output logic                          out_valid,
  output drfd_pkg::result_t             out_res
);

  localparam int POS_W  = $clog2(MAX_ROW_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_ROW_LEN);
  localparam int CMP_W  = (POS_W > drfd_pkg::ELEM_IDX_W) ? POS_W : drfd_pkg::ELEM_IDX_W;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  drfd_pkg::q16_t mem [MAX_ROW_LEN];

  pos_t                      pos;
  pos_t                      wpos;
  logic [ROW_INDEX_BITS-1:0] row_counter;

  drfd_pkg::q16_t     rd_data;
  logic               rd_ok;
  drfd_pkg::ld_dest_t rd_tag;
  drfd_pkg::cls_t     rd_cls_q;
  drfd_pkg::q16_t     elem;

  drfd_pkg::q16_t x, y, w, h, obj, ka, kb, kc;

  logic signed [63:0] prod;
  logic               scan_p;
  drfd_pkg::cls_t     cls_p;
  drfd_pkg::q16_t     s_sat;
  drfd_pkg::q16_t     best;
  drfd_pkg::cls_t     best_cls;
  logic               found;
  logic               is_face;

  function automatic drfd_pkg::q16_t sat_prod(input logic signed [63:0] p);
    if (p[63:47] == {17{p[63]}}) begin
      return p[47:16];
    end else if (p[63]) begin
      return 32'sh8000_0000;
    end
    return 32'sh7fff_ffff;
  endfunction

  // floor((2c +/- s) / 2), saturated to 32 bits.
  function automatic drfd_pkg::q16_t corner(input drfd_pkg::q16_t c, input drfd_pkg::q16_t s,
                                             input logic add);
    logic signed [33:0] sum;
    logic signed [32:0] half;
    if (add) begin
      sum = {c[31], c, 1'b0} + {{2{s[31]}}, s};
    end else begin
      sum = {c[31], c, 1'b0} - {{2{s[31]}}, s};
    end
    half = sum[33:1];
    if (half[32] != half[31]) begin
      return half[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return half[31:0];
  endfunction

  assign wpos    = first ? '0 : pos;
  assign elem    = rd_ok ? rd_data : '0;
  assign s_sat   = sat_prod(prod);
  assign is_face = (head_mode == drfd_pkg::MODE_FACE);

  // Row store: one write port for incoming elements, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.in_take && wpos < pos_t'(MAX_ROW_LEN)) begin
      mem[addr_t'(wpos)] <= value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr_t'(cmp_t'(cmd.rd_idx))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      row_counter <= '0;
      rd_ok       <= 1'b0;
      rd_tag      <= drfd_pkg::LD_NONE;
      scan_p      <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (cmd.in_take) begin
        if (first) row_counter <= '0;
        pos <= (wpos < pos_t'(MAX_ROW_LEN)) ? pos_t'(wpos + 1'b1) : wpos;
      end else if (cmd.end_row) begin
        pos         <= '0;
        row_counter <= row_counter + 1'b1;
      end
      rd_ok  <= cmd.rd_en && (cmp_t'(cmd.rd_idx) < cmp_t'(pos));
      rd_tag <= cmd.rd_en ? cmd.rd_dest : drfd_pkg::LD_NONE;
      scan_p <= (rd_tag == drfd_pkg::LD_SCAN);
      if (cmd.init_best) begin
        found <= 1'b0;
      end else if (scan_p && s_sat > best) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cls_q <= cmd.rd_cls;
    cls_p    <= rd_cls_q;
    case (rd_tag)
      drfd_pkg::LD_X:    x  <= elem;
      drfd_pkg::LD_Y:    y  <= elem;
      drfd_pkg::LD_W:    w  <= elem;
      drfd_pkg::LD_H:    h  <= elem;
      drfd_pkg::LD_OBJ:  obj <= (head_mode == drfd_pkg::MODE_V8) ? drfd_pkg::ONE_Q16 : elem;
      drfd_pkg::LD_SCAN: prod <= obj * elem;
      drfd_pkg::LD_KA:   ka <= elem;
      drfd_pkg::LD_KB:   kb <= elem;
      drfd_pkg::LD_KC:   kc <= elem;
      default:           prod <= prod;
    endcase
    if (cmd.init_best) begin
      best     <= $signed({15'd0, cls_thr});
      best_cls <= '0;
    end else if (scan_p && s_sat > best) begin
      best     <= s_sat;
      best_cls <= cls_p;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_box || cmd.emit_kp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_box || cmd.emit_kp) begin
      out_res.class_label <= best_cls;
      out_res.score       <= best;
      out_res.box_index   <= drfd_pkg::box_idx_t'(row_counter);
      out_res.last_of_run <= cmd.emit_last;
    end
    if (cmd.emit_box) begin
      out_res.kind         <= 1'b0;
      out_res.point_number <= '0;
      out_res.coord_a      <= corner(x, w, 1'b0);
      out_res.coord_b      <= corner(y, h, 1'b0);
      out_res.coord_c      <= corner(x, w, 1'b1);
      out_res.coord_d      <= corner(y, h, 1'b1);
    end else if (cmd.emit_kp) begin
      out_res.kind         <= 1'b1;
      out_res.point_number <= cmd.point;
      out_res.coord_a      <= ka;
      out_res.coord_b      <= kb;
      out_res.coord_c      <= is_face ? drfd_pkg::HALF_Q16 : kc;
      out_res.coord_d      <= '0;
    end
  end

  always_comb begin
    status.obj_pass  = (obj > $signed({15'd0, obj_thr}));
    status.found     = found;
    status.pipe_busy = (rd_tag != drfd_pkg::LD_NONE) || scan_p;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

/* design/detection_row_filter_decode.sv */
// Row elements are taken one per cycle while a row is open; the transfer marked tlast closes it.
// Closing a row stalls the input until the row is decoded, longer for a box row than for a row
// rejected on objectness, set by the single read port of the row store and the
// one-class-per-cycle multiply and compare pipeline. Pose and face keypoints add to the stall.
// Reset is synchronous and active high; no clearing pass is needed.
module detection_row_filter_decode #(
  parameter int MAX_ROW_LEN    = drfd_pkg::MAX_ROW_LEN_DEF,
  parameter int ROW_INDEX_BITS = drfd_pkg::ROW_INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [drfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [drfd_pkg::THR_W-1:0]          cfg_wr_data,
  // Row element stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [drfd_pkg::IN_TDATA_W-1:0]     s_tdata,   // value[31:0]
  input  logic                                s_tlast,   // last_in_row
  input  logic                                s_tuser,   // first_of_frame
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // class_label[6:0], score[38:7], box_index[54:39], point_number[59:55],
  // coord_a[91:60], coord_b[123:92], coord_c[155:124], coord_d[187:156], zero pad
  output logic [drfd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tuser,   // kind
  output logic                                m_tlast    // last_of_run
);

  // Configuration registers. They must be written only while the block is idle; the block does not enforce this.
  logic [drfd_pkg::MODE_W-1:0] head_mode;
  drfd_pkg::cls_t              class_count;
  logic [drfd_pkg::THR_W-1:0]  obj_thr;
  logic [drfd_pkg::THR_W-1:0]  cls_thr;

  drfd_pkg::ctrl_cmd_t  cmd;
  drfd_pkg::dp_status_t status;
  drfd_pkg::result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_mode   <= drfd_pkg::HEAD_MODE_RST;
      class_count <= drfd_pkg::CLASS_COUNT_RST;
      obj_thr     <= drfd_pkg::OBJ_THR_RST;
      cls_thr     <= drfd_pkg::CLS_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        drfd_pkg::CFG_HEAD_MODE:   head_mode   <= cfg_wr_data[drfd_pkg::MODE_W-1:0];
        drfd_pkg::CFG_CLASS_COUNT: class_count <= cfg_wr_data[drfd_pkg::CLASS_W-1:0];
        drfd_pkg::CFG_OBJ_THR:     obj_thr     <= cfg_wr_data;
        drfd_pkg::CFG_CLS_THR:     cls_thr     <= cfg_wr_data;
        default:                   head_mode   <= head_mode;
      endcase
    end
  end

  // The controller walks each closed row through load, class scan and emission steps.
  drfd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tlast     (s_tlast),
    .s_tready    (s_tready),
    .head_mode   (head_mode),
    .class_count (class_count),
    .status      (status),
    .cmd         (cmd)
  );

  // The datapath holds the row store, the argmax pipeline and the output register,
  // so a finished result waits there while the controller moves on.
  drfd_datapath #(
    .MAX_ROW_LEN    (MAX_ROW_LEN),
    .ROW_INDEX_BITS (ROW_INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (drfd_pkg::q16_t'(s_tdata)),
    .first     (s_tuser),
    .head_mode (head_mode),
    .obj_thr   (obj_thr),
    .cls_thr   (cls_thr),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = {{drfd_pkg::OUT_PAD_W{1'b0}}, res.coord_d, res.coord_c, res.coord_b,
                    res.coord_a, res.point_number, res.box_index, res.score, res.class_label};
  assign m_tuser = res.kind;
  assign m_tlast = res.last_of_run;

endmodule

/* design/drfd_checker.sv */
module drfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [drfd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // Closing a row stops input while the row is decoded.
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after row close");

  // Box results carry keypoint number zero.
  a_box_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[59:55] == 5'd0)
    else $error("box result with nonzero keypoint number");

  // Keypoint results carry a zero fourth coordinate.
  a_kp_coord_d: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[187:156] == 32'd0)
    else $error("keypoint result with nonzero coord_d");

endmodule

bind detection_row_filter_decode drfd_checker u_drfd_checker (.*);

/* sim/drfd_scoreboard_pkg.sv */
`timescale 1ns / 100ps
package drfd_scoreboard_pkg;
  import drfd_pkg::*;

  class row_decode_scoreboard;
    // Register copies, written only while the block is idle.
    logic [MODE_W-1:0]  head_mode;
    logic [CLASS_W-1:0] class_count;
    logic [THR_W-1:0]   obj_thr;
    logic [THR_W-1:0]   cls_thr;

    // Row under construction and the running row number.
    int unsigned row_fill;
    q16_t        row_buf[MAX_ROW_LEN_DEF];
    box_idx_t    row_number;

    result_t     pending_detections[$];
    int unsigned mismatch_count;
    int unsigned results_predicted;

    function new();
      head_mode         = HEAD_MODE_RST;
      class_count       = CLASS_COUNT_RST;
      obj_thr           = OBJ_THR_RST;
      cls_thr           = CLS_THR_RST;
      row_fill          = 0;
      row_number        = '0;
      mismatch_count    = 0;
      results_predicted = 0;
      foreach (row_buf[i]) row_buf[i] = '0;
    endfunction

    function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [THR_W-1:0] data);
      case (addr)
        CFG_HEAD_MODE:   head_mode = data[MODE_W-1:0];
        CFG_CLASS_COUNT: class_count = data[CLASS_W-1:0];
        CFG_OBJ_THR:     obj_thr = data;
        CFG_CLS_THR:     cls_thr = data;
        default: ;
      endcase
    endfunction

    // Elements that did not arrive in this row read as zero.
    function longint element(int unsigned idx);
      if (idx < row_fill) return longint'(row_buf[idx]);
      return 0;
    endfunction

    function q16_t saturate_q16(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
      return q16_t'(v);
    endfunction

    function void queue_result(result_t r);
      pending_detections.insert(pending_detections.size(), r);
      results_predicted++;
    endfunction

    function void decode_row();
      longint      obj;
      longint      best;
      longint      prod;
      longint      x;
      longint      y;
      longint      w;
      longint      h;
      int unsigned base;
      int unsigned b;
      bit          found;
      result_t     r;
      base  = (head_mode == MODE_V8) ? CLS_BASE_V8 : CLS_BASE;
      obj   = (head_mode == MODE_V8) ? longint'(ONE_Q16) : element(4);
      best  = longint'(cls_thr);
      found = 1'b0;
      r     = '0;
      if (obj > longint'(obj_thr)) begin
        for (int unsigned c = 0; c < class_count; c++) begin
          // Floor of the Q16.16 product, then clamp; strict compare keeps the first tie.
          prod = longint'(saturate_q16((obj * element(base + c)) >>> 16));
          if (prod > best) begin
            best          = prod;
            r.class_label = c[CLASS_W-1:0];
            found         = 1'b1;
          end
        end
      end
      if (found) begin
        x              = element(0);
        y              = element(1);
        w              = element(2);
        h              = element(3);
        r.kind         = 1'b0;
        r.score        = q16_t'(best);
        r.box_index    = row_number;
        r.point_number = '0;
        r.coord_a      = saturate_q16((2 * x - w) >>> 1);
        r.coord_b      = saturate_q16((2 * y - h) >>> 1);
        r.coord_c      = saturate_q16((2 * x + w) >>> 1);
        r.coord_d      = saturate_q16((2 * y + h) >>> 1);
        r.last_of_run  = !(head_mode == MODE_POSE || head_mode == MODE_FACE);
        queue_result(r);
        r.kind    = 1'b1;
        r.coord_d = '0;
        if (head_mode == MODE_POSE) begin
          for (int unsigned k = 0; k < POSE_POINTS; k++) begin
            b              = POSE_BASE + POSE_STRIDE * k;
            r.point_number = k[POINT_W-1:0];
            r.coord_a      = q16_t'(element(b));
            r.coord_b      = q16_t'(element(b + 1));
            r.coord_c      = q16_t'(element(b + 2));
            r.last_of_run  = (k == POSE_POINTS - 1);
            queue_result(r);
          end
        end else if (head_mode == MODE_FACE) begin
          for (int unsigned k = 0; k < FACE_POINTS; k++) begin
            b              = FACE_BASE + FACE_STRIDE * k;
            r.point_number = k[POINT_W-1:0];
            r.coord_a      = q16_t'(element(b));
            r.coord_b      = q16_t'(element(b + 1));
            r.coord_c      = HALF_Q16;
            r.last_of_run  = (k == FACE_POINTS - 1);
            queue_result(r);
          end
        end
      end
      row_fill   = 0;
      row_number = row_number + 1'b1;
    endfunction

    function void note_element(q16_t value, bit last, bit first);
      if (first) begin
        row_fill   = 0;
        row_number = '0;
      end
      if (row_fill < MAX_ROW_LEN_DEF) begin
        row_buf[row_fill] = value;
        row_fill++;
      end
      if (last) decode_row();
    endfunction

    function void report(string what, logic [Q16_W-1:0] want, logic [Q16_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s differs: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_detections.size() == 0) begin
        report("unexpected result, box_index", '0, 32'(got.box_index));
        return;
      end
      want = pending_detections.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.class_label !== want.class_label)
        report("class_label", want.class_label, got.class_label);
      if (got.score !== want.score) report("score", want.score, got.score);
      if (got.box_index !== want.box_index) report("box_index", want.box_index, got.box_index);
      if (got.point_number !== want.point_number)
        report("point_number", want.point_number, got.point_number);
      if (got.coord_a !== want.coord_a) report("coord_a", want.coord_a, got.coord_a);
      if (got.coord_b !== want.coord_b) report("coord_b", want.coord_b, got.coord_b);
      if (got.coord_c !== want.coord_c) report("coord_c", want.coord_c, got.coord_c);
      if (got.coord_d !== want.coord_d) report("coord_d", want.coord_d, got.coord_d);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int unsigned outstanding();
      return pending_detections.size();
    endfunction
  endclass

endpackage

/* sim/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import drfd_pkg::*;
  import drfd_scoreboard_pkg::*;

  // Even the slowest row close, with 127 classes and pose keypoints, is short next to
  // this limit, so it leaves a wide margin over any correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Quiet time after the last expected result: covers a row that is still being
  // scanned but will produce nothing.
  localparam int DRAIN_CYCLES = 200;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [THR_W-1:0]       cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  row_decode_scoreboard row_sb = new();

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  // Stimulus-side view of the current setting, used only to shape the rows.
  logic [MODE_W-1:0]  cur_mode = MODE_DETECT;
  logic [CLASS_W-1:0] cur_count = CLASS_COUNT_RST;
  logic [THR_W-1:0]   cur_obj_thr = OBJ_THR_RST;
  q16_t               row_vals[$];

  always #5 clk = ~clk;

  detection_row_filter_decode i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Back pressure on the result stream changes only at the falling edge.
  always @(negedge clk) begin
    m_tready <= !chance(stall_pct);
  end

  // Every accepted result transfer is unpacked from the bus layout and checked
  // against the oldest prediction. The same process guards the run length.
  always @(posedge clk) begin
    result_t got;
    cycle_count++;
    if (!rst && m_tvalid && m_tready) begin
      got.kind         = m_tuser;
      got.class_label  = m_tdata[6:0];
      got.score        = m_tdata[38:7];
      got.box_index    = m_tdata[54:39];
      got.point_number = m_tdata[59:55];
      got.coord_a      = m_tdata[91:60];
      got.coord_b      = m_tdata[123:92];
      got.coord_c      = m_tdata[155:124];
      got.coord_d      = m_tdata[187:156];
      got.last_of_run  = m_tlast;
      row_sb.check_result(got);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One register write per cycle; the caller drops the write enable afterwards.
  task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [THR_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= addr;
    cfg_wr_data <= data;
    row_sb.write_register(addr, data);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [MODE_W-1:0] mode, logic [CLASS_W-1:0] count,
                               logic [THR_W-1:0] obj_thr, logic [THR_W-1:0] cls_thr);
    cur_mode    = mode;
    cur_count   = count;
    cur_obj_thr = obj_thr;
    write_register(CFG_HEAD_MODE, THR_W'(mode));
    write_register(CFG_CLASS_COUNT, THR_W'(count));
    write_register(CFG_OBJ_THR, obj_thr);
    write_register(CFG_CLS_THR, cls_thr);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one row element and returns at the falling edge after its transfer.
  // The sender may hold tvalid low for a random number of cycles first.
  task automatic send_element(q16_t value, bit last, bit first);
    while (chance(send_idle_pct)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    row_sb.note_element(value, last, first);
    @(negedge clk);
  endtask

  // Sends row_vals as one row. A restart index puts first_of_frame in the middle
  // of the row, which throws away what was sent of it so far.
  task automatic send_row(bit frame_start, int restart_at);
    for (int i = 0; i < row_vals.size(); i++)
      send_element(row_vals[i], i == row_vals.size() - 1, (i == 0 && frame_start) ||
                   i == restart_at);
  endtask

  // Waits until every predicted result has been seen, then lets the block finish
  // any row that is still being scanned without a result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (row_sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Element values are mostly in a useful range: box fields around zero,
  // objectness just above its threshold, class scores between 0 and 3.0 so that products
  // land on both sides of the class threshold. One in eight is fully random and
  // class/keypoint values sometimes repeat the previous one to force ties.
  function automatic q16_t pick_value(int unsigned i, q16_t prev);
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return q16_t'($urandom);
    if (i < 4) return q16_t'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    if (i == 4 && cur_mode != MODE_V8) begin
      if (r == 1) return q16_t'($urandom_range(cur_obj_thr));
      return q16_t'(cur_obj_thr + $urandom_range(32'h0001_0000, 1));
    end
    if (r == 1) return prev;
    return q16_t'($urandom_range(32'h0003_0000));
  endfunction

  // Most rows are exactly as long as the mode needs; some are cut short, some
  // run past the end, which with large class counts also overflows the row store.
  function automatic void build_row(output bit frame_start, output int restart_at);
    int unsigned needed;
    int unsigned len;
    int unsigned pick;
    q16_t        v;
    needed = ((cur_mode == MODE_V8) ? CLS_BASE_V8 : CLS_BASE) + cur_count;
    if (cur_mode == MODE_POSE && needed < POSE_BASE + POSE_STRIDE * POSE_POINTS)
      needed = POSE_BASE + POSE_STRIDE * POSE_POINTS;
    if (cur_mode == MODE_FACE && needed < FACE_BASE + FACE_STRIDE * FACE_POINTS)
      needed = FACE_BASE + FACE_STRIDE * FACE_POINTS;
    pick = $urandom_range(19);
    if (pick < 2) len = $urandom_range(needed - 1, 1);
    else if (pick < 4) len = needed + $urandom_range(10, 1);
    else len = needed;
    row_vals.delete();
    v = '0;
    for (int unsigned i = 0; i < len; i++) begin
      v = pick_value(i, v);
      row_vals.insert(row_vals.size(), v);
    end
    frame_start = ($urandom_range(9) == 0);
    restart_at  = (len > 1 && $urandom_range(15) == 0) ? int'($urandom_range(len - 1, 1)) : -1;
  endfunction

  initial begin
    int unsigned elems;
    int unsigned results_at_start;
    bit          frame_start;
    int          restart_at;
    idle_style_t idle_style;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed rows: two classes, thresholds at zero.
    apply_setting(MODE_DETECT, 7'd2, '0, '0);
    // Largest values everywhere: saturated product, saturated corners, and a tie
    // between the two classes that the first class must win.
    row_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_row(1'b1, -1);
    // Odd negative centre and negative size check the floor of the corners; a
    // negative first class loses to a tiny positive second class.
    row_vals = '{-32'sd3, 32'sd1, -32'sd1, 32'sd7, 32'sh0001_0000, -32'sh0001_0000, 32'sd1};
    send_row(1'b0, -1);
    // Short row: objectness never arrives and reads as zero, so it is rejected.
    row_vals = '{32'sh1234_5678, -32'sh1234_5678, 32'sd5};
    send_row(1'b0, -1);
    // A frame start two elements in drops the partial row and restarts the index.
    row_vals = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0064_0000, 32'sh0032_0000,
                 32'sh0010_0000, 32'sh0008_0000, 32'sh0001_8000, 32'sh0000_8000,
                 32'sh0002_0000};
    send_row(1'b0, 2);
    wait_drained();

    // Random phases: each mode twice, with extreme and random register values and
    // a different idle pattern on the two streams.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          idle_style = IDLE_NONE;
          apply_setting(MODE_DETECT, CLASS_W'($urandom_range(12, 1)), '0, '0);
        end
        1: begin
          idle_style = IDLE_NONE;
          apply_setting(MODE_V8, CLASS_W'($urandom_range(24, 1)),
                        THR_W'($urandom_range(65535)), 17'd65536);
        end
        2: begin
          idle_style = IDLE_SENDER;
          apply_setting(MODE_POSE, CLASS_W'($urandom_range(6, 1)),
                        THR_W'($urandom_range(65536)), THR_W'($urandom_range(65536)));
        end
        3: begin
          idle_style = IDLE_SENDER;
          apply_setting(MODE_FACE, 7'd1, 17'd65536, '0);
        end
        4: begin
          idle_style = IDLE_RECEIVER;
          apply_setting(MODE_DETECT, 7'd127, THR_W'($urandom_range(65536)),
                        THR_W'($urandom_range(65536)));
        end
        5: begin
          idle_style = IDLE_RECEIVER;
          apply_setting(MODE_V8, 7'd0, THR_W'($urandom_range(65536)),
                        THR_W'($urandom_range(65536)));
        end
        6: begin
          idle_style = IDLE_BOTH;
          apply_setting(MODE_POSE, CLASS_W'($urandom_range(12, 1)), '0, 17'd65536);
        end
        default: begin
          idle_style = IDLE_BOTH;
          apply_setting(MODE_FACE, CLASS_W'($urandom_range(12, 1)),
                        THR_W'($urandom_range(65536)), THR_W'($urandom_range(65536)));
        end
      endcase
      case (idle_style)
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct = 59;
          stall_pct     = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          stall_pct     = 59;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct     = 8;
        end
      endcase
      // Keep sending rows until the phase has its share of elements and, where
      // the setting allows it, a couple of detections.
      elems            = 0;
      results_at_start = row_sb.results_predicted;
      while (elems < 30 || (row_sb.results_predicted - results_at_start < 2 && elems < 50)) begin
        build_row(frame_start, restart_at);
        send_row(frame_start, restart_at);
        elems += row_vals.size();
      end
      wait_drained();
    end

    if (row_sb.mismatch_count == 0 && row_sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
